FILE: src/idll_pkg.sv
// ============================================================================
// idll_pkg
// Shared constants, command and status codes, and node memory request types
// for the indexed doubly linked list unit.
// ============================================================================
package idll_pkg;

	// pool geometry
	localparam int POOL_NODES = 1024;
	localparam int HANDLE_W   = $clog2(POOL_NODES);
	localparam int SLOT_W     = HANDLE_W + 1;
	localparam int VALUE_W    = 32;
	localparam int OP_W       = 4;
	localparam int STATUS_W   = 2;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// command codes
	localparam op_t OP_INS_BEFORE = 4'd0;
	localparam op_t OP_INS_AFTER  = 4'd1;
	localparam op_t OP_PUSH_FRONT = 4'd2;
	localparam op_t OP_PUSH_BACK  = 4'd3;
	localparam op_t OP_POP_FRONT  = 4'd4;
	localparam op_t OP_POP_BACK   = 4'd5;
	localparam op_t OP_ERASE      = 4'd6;
	localparam op_t OP_GET        = 4'd7;
	localparam op_t OP_NEXT       = 4'd8;
	localparam op_t OP_PREV       = 4'd9;
	localparam op_t OP_CLEAR      = 4'd10;
	localparam op_t OP_STATUS     = 4'd11;

	// result status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_BAD   = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	// one read and per-array writes into the node memory
	typedef struct packed {
		logic    rd_en;
		handle_t rd_addr;
		logic    prev_we;
		handle_t prev_addr;
		handle_t prev_data;
		logic    next_we;
		handle_t next_addr;
		handle_t next_data;
		logic    value_we;
		handle_t value_addr;
		value_t  value_data;
		logic    live_we;
		handle_t live_addr;
		logic    live_data;
	} mem_req_t;

	// registered read data of one node
	typedef struct packed {
		handle_t prev;
		handle_t next;
		value_t  value;
		logic    live;
	} mem_rsp_t;

endpackage

FILE: src/indexed_doubly_linked_list_unit.sv
// Flow: a command taken in S_IDLE runs in S_EXEC, and done is registered from there;
// a successful insert or push passes through S_LINK before done is raised.
// The node memory's single write port per array keeps the new node and its neighbor links
// in separate states (S_EXEC, then S_LINK). A new command may be taken in the cycle its
// result is shown.
// Reset: arst_n clears the list to empty with the sentinel alone; no clearing pass.
// ============================================================================
// indexed_doubly_linked_list_unit
// Circular doubly linked list over a node pool with a register-held sentinel,
// run by a small sequencer: read the node, update, then patch neighbor links.
// ============================================================================
module indexed_doubly_linked_list_unit
	import idll_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  op_t     op,
	input  handle_t node,
	input  value_t  value,
	output logic    done,
	output status_t status,
	output handle_t node_out,
	output value_t  value_out,
	output handle_t count
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LINK = 2'd2;

	logic [1:0] state_q, state_d;
	logic       done_q, done_d;

	// command and pool registers
	op_t     op_q;
	value_t  value_q;
	handle_t addr_q, addr_d;
	handle_t sent_prev_q, sent_prev_d;
	handle_t sent_next_q, sent_next_d;
	slot_t   slots_q, slots_d;
	handle_t cnt_q, cnt_d;
	handle_t fresh_q, pos_q, before_q;
	handle_t sel_pos, sel_before;

	// result registers
	status_t status_q, status_d;
	handle_t node_out_q, node_out_d;
	value_t  value_out_q, value_out_d;

	mem_req_t req;
	mem_rsp_t rsp;

	// current node view with the sentinel taken from registers
	logic    is_sent;
	handle_t cur_prev, cur_next;
	value_t  cur_value;
	logic    cur_live, in_range, h_ok, full;
	handle_t fresh;

	idll_node_mem u_node_mem (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	assign is_sent   = (addr_q == '0);
	assign cur_prev  = is_sent ? sent_prev_q : rsp.prev;
	assign cur_next  = is_sent ? sent_next_q : rsp.next;
	assign cur_value = is_sent ? '0 : rsp.value;
	assign cur_live  = is_sent | rsp.live;
	assign in_range  = ({1'b0, addr_q} < slots_q);
	assign h_ok      = in_range & cur_live;
	assign full      = (slots_q >= SLOT_W'(POOL_NODES));
	assign fresh     = slots_q[HANDLE_W-1:0];

	// sequencer
	always_comb begin
		req         = '0;
		state_d     = state_q;
		done_d      = 1'b0;
		addr_d      = addr_q;
		sent_prev_d = sent_prev_q;
		sent_next_d = sent_next_q;
		slots_d     = slots_q;
		cnt_d       = cnt_q;
		status_d    = ST_OK;
		node_out_d  = '0;
		value_out_d = '0;
		sel_pos     = '0;
		sel_before  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						OP_POP_FRONT: addr_d = sent_next_q;
						OP_POP_BACK:  addr_d = sent_prev_q;
						default:      addr_d = node;
					endcase
					req.rd_en   = 1'b1;
					req.rd_addr = addr_d;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				case (op_q)
					OP_INS_BEFORE, OP_INS_AFTER, OP_PUSH_FRONT, OP_PUSH_BACK: begin
						case (op_q)
							OP_INS_BEFORE: begin
								sel_pos    = addr_q;
								sel_before = cur_prev;
							end
							OP_INS_AFTER: begin
								sel_pos    = cur_next;
								sel_before = addr_q;
							end
							OP_PUSH_FRONT: begin
								sel_pos    = sent_next_q;
								sel_before = '0;
							end
							default: begin
								sel_pos    = '0;
								sel_before = sent_prev_q;
							end
						endcase
						if ((op_q == OP_INS_BEFORE || op_q == OP_INS_AFTER) && !h_ok) begin
							status_d = ST_BAD;
						end else if (full) begin
							status_d = ST_FULL;
						end else begin
							// new node itself; neighbor links follow next cycle
							req.prev_we    = 1'b1;
							req.prev_addr  = fresh;
							req.prev_data  = sel_before;
							req.next_we    = 1'b1;
							req.next_addr  = fresh;
							req.next_data  = sel_pos;
							req.value_we   = 1'b1;
							req.value_addr = fresh;
							req.value_data = value_q;
							req.live_we    = 1'b1;
							req.live_addr  = fresh;
							req.live_data  = 1'b1;
							slots_d        = slots_q + 1'b1;
							cnt_d          = cnt_q + 1'b1;
							node_out_d     = fresh;
							state_d        = S_LINK;
							done_d         = 1'b0;
						end
					end
					OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
						if (op_q != OP_ERASE && cnt_q == '0) begin
							status_d = ST_EMPTY;
						end else if (op_q == OP_ERASE && (is_sent || !h_ok)) begin
							status_d = ST_BAD;
						end else begin
							// unlink: predecessor and successor point at each other
							if (cur_prev == '0) begin
								sent_next_d = cur_next;
							end else begin
								req.next_we   = 1'b1;
								req.next_addr = cur_prev;
								req.next_data = cur_next;
							end
							if (cur_next == '0) begin
								sent_prev_d = cur_prev;
							end else begin
								req.prev_we   = 1'b1;
								req.prev_addr = cur_next;
								req.prev_data = cur_prev;
							end
							req.live_we   = 1'b1;
							req.live_addr = addr_q;
							req.live_data = 1'b0;
							cnt_d         = cnt_q - 1'b1;
							node_out_d    = cur_next;
						end
					end
					OP_GET: begin
						if (!in_range) begin
							status_d = ST_BAD;
						end else begin
							value_out_d = cur_value;
							if (!cur_live) begin
								status_d = ST_BAD;
							end
						end
					end
					OP_NEXT, OP_PREV: begin
						if (!h_ok) begin
							status_d = ST_BAD;
						end else begin
							node_out_d = (op_q == OP_NEXT) ? cur_next : cur_prev;
						end
					end
					OP_CLEAR: begin
						sent_prev_d = '0;
						sent_next_d = '0;
						slots_d     = SLOT_W'(1);
						cnt_d       = '0;
					end
					OP_STATUS: begin
						if (cnt_q == '0) begin
							status_d = ST_EMPTY;
						end else begin
							node_out_d = sent_next_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_LINK: begin
				// hook the new node into its neighbors
				if (before_q == '0) begin
					sent_next_d = fresh_q;
				end else begin
					req.next_we   = 1'b1;
					req.next_addr = before_q;
					req.next_data = fresh_q;
				end
				if (pos_q == '0) begin
					sent_prev_d = fresh_q;
				end else begin
					req.prev_we   = 1'b1;
					req.prev_addr = pos_q;
					req.prev_data = fresh_q;
				end
				state_d = S_IDLE;
				done_d  = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			sent_prev_q <= '0;
			sent_next_q <= '0;
			slots_q     <= SLOT_W'(1);
			cnt_q       <= '0;
		end else begin
			state_q     <= state_d;
			done_q      <= done_d;
			sent_prev_q <= sent_prev_d;
			sent_next_q <= sent_next_d;
			slots_q     <= slots_d;
			cnt_q       <= cnt_d;
		end
	end

	// command capture and result payload
	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		if (state_q == S_IDLE && start) begin
			op_q    <= op;
			value_q <= value;
		end
		if (state_q == S_EXEC) begin
			status_q    <= status_d;
			node_out_q  <= node_out_d;
			value_out_q <= value_out_d;
			fresh_q     <= fresh;
			pos_q       <= sel_pos;
			before_q    <= sel_before;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign node_out  = node_out_q;
	assign value_out = value_out_q;
	assign count     = cnt_q;

endmodule

FILE: src/idll_node_mem.sv
// ============================================================================
// idll_node_mem
// Node storage: previous link, next link, value and live mark arrays, each
// with one write port, a shared read address and registered read data.
// ============================================================================
module idll_node_mem
	import idll_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	handle_t prev_mem  [POOL_NODES];
	handle_t next_mem  [POOL_NODES];
	value_t  value_mem [POOL_NODES];
	logic    live_mem  [POOL_NODES];

	handle_t rd_prev_q;
	handle_t rd_next_q;
	value_t  rd_value_q;
	logic    rd_live_q;

	// array writes
	always_ff @(posedge clk) begin
		if (req.prev_we) begin
			prev_mem[req.prev_addr] <= req.prev_data;
		end
		if (req.next_we) begin
			next_mem[req.next_addr] <= req.next_data;
		end
		if (req.value_we) begin
			value_mem[req.value_addr] <= req.value_data;
		end
		if (req.live_we) begin
			live_mem[req.live_addr] <= req.live_data;
		end
	end

	// registered read of one node
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_prev_q  <= prev_mem[req.rd_addr];
			rd_next_q  <= next_mem[req.rd_addr];
			rd_value_q <= value_mem[req.rd_addr];
			rd_live_q  <= live_mem[req.rd_addr];
		end
	end

	assign rsp.prev  = rd_prev_q;
	assign rsp.next  = rd_next_q;
	assign rsp.value = rd_value_q;
	assign rsp.live  = rd_live_q;

endmodule

FILE: src/idll_checker.sv
// ============================================================================
// idll_checker
// Port-level checks on the command handshake and result transactions of the
// indexed doubly linked list unit.
// ============================================================================
module idll_checker
	import idll_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input status_t status,
	input handle_t node_out,
	input handle_t count
);

	// a result is shown only once the unit is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transaction makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but unit not busy");

	// each result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// an empty report comes with no live nodes
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (count == '0 && node_out == '0))
		else $error("empty status with live nodes");

	// a refused handle returns no node
	a_bad_node: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_BAD) |-> (node_out == '0))
		else $error("bad handle status with nonzero node");

endmodule

bind indexed_doubly_linked_list_unit idll_checker u_idll_checker (.*);

FILE: dv/indexed_doubly_linked_list_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// indexed_doubly_linked_list_unit_test
// Self-checking bench for the linked list unit. A directed table covers the
// empty list, bad handles, erased nodes and clear. Random traffic follows,
// including a run that fills the node pool. Every result is compared against
// the typed expectation of its table row or a behavioral copy of the list.
// ============================================================================
module indexed_doubly_linked_list_unit_test;
	import idll_pkg::*;

	localparam op_t OP_UNUSED_LO  = 4'd12;
	localparam op_t OP_UNUSED_HI  = 4'd15;
	localparam int  STALL_LIMIT   = 200;
	localparam int  DRAIN_CYCLES  = 8;
	localparam int  DIRECTED_ROWS = 27;
	localparam int  MIX_LEN       = 13;
	// command mix in percent, by op code; the last entry covers the unused codes
	localparam int  MIX_NORMAL [MIX_LEN] = '{10, 10, 8, 8, 6, 6, 12, 12, 8, 8, 2, 5, 5};
	localparam int  MIX_GROW   [MIX_LEN] = '{25, 25, 20, 20, 1, 1, 2, 2, 1, 1, 0, 1, 1};

	typedef struct packed {
		status_t status;
		handle_t node_out;
		value_t  value_out;
		handle_t count;
	} list_result_t;

	typedef struct packed {
		op_t          cmd;
		handle_t      h;
		value_t       v;
		logic         typed;
		list_result_t want;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	op_t     op;
	handle_t node;
	value_t  value;
	logic    done;
	status_t status;
	handle_t node_out;
	value_t  value_out;
	handle_t count;

	// behavioral copy of the list
	int                 lnk_prev [POOL_NODES];
	int                 lnk_next [POOL_NODES];
	bit [VALUE_W-1:0]   val_mem  [POOL_NODES];
	bit                 alive    [POOL_NODES];
	int                 slot_fill;
	int                 live_total;
	// live non-sentinel handles, for picking well-formed targets
	int                 live_list [POOL_NODES];
	int                 live_slot [POOL_NODES];
	int                 live_n;

	list_result_t       awaited_results [$];
	int                 mismatches;
	int                 stall_cycles;
	dir_row_t           dir_rows [DIRECTED_ROWS];

	indexed_doubly_linked_list_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.node      (node),
		.value     (value),
		.done      (done),
		.status    (status),
		.node_out  (node_out),
		.value_out (value_out),
		.count     (count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// empty list with the sentinel alone
	function automatic void clear_list();
		lnk_prev[0] = 0;
		lnk_next[0] = 0;
		val_mem[0]  = '0;
		alive[0]    = 1'b1;
		slot_fill   = 1;
		live_total  = 0;
		live_n      = 0;
	endfunction

	// apply one command to the list copy and return its result
	function automatic list_result_t apply_command(op_t cmd, handle_t h, value_t v);
		list_result_t res;
		bit           valid;
		bit           do_link;
		bit           do_unlink;
		int           pos;
		int           target;
		int           fresh;
		int           pred;
		int           succ;
		int           idx;
		res       = '0;
		valid     = (int'(h) < slot_fill) && alive[h];
		do_link   = 1'b0;
		do_unlink = 1'b0;
		pos       = 0;
		target    = 0;
		case (cmd)
			OP_INS_BEFORE, OP_INS_AFTER: begin
				if (!valid)
					res.status = ST_BAD;
				else if (slot_fill >= POOL_NODES)
					res.status = ST_FULL;
				else begin
					do_link = 1'b1;
					pos     = (cmd == OP_INS_BEFORE) ? int'(h) : lnk_next[h];
				end
			end
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (slot_fill >= POOL_NODES)
					res.status = ST_FULL;
				else begin
					do_link = 1'b1;
					pos     = (cmd == OP_PUSH_FRONT) ? lnk_next[0] : 0;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (live_total == 0)
					res.status = ST_EMPTY;
				else begin
					do_unlink = 1'b1;
					target    = (cmd == OP_POP_FRONT) ? lnk_next[0] : lnk_prev[0];
				end
			end
			OP_ERASE: begin
				if (h == '0 || !valid)
					res.status = ST_BAD;
				else begin
					do_unlink = 1'b1;
					target    = int'(h);
				end
			end
			OP_GET: begin
				if (int'(h) >= slot_fill)
					res.status = ST_BAD;
				else begin
					res.value_out = val_mem[h];
					if (!alive[h])
						res.status = ST_BAD;
				end
			end
			OP_NEXT, OP_PREV: begin
				if (!valid)
					res.status = ST_BAD;
				else
					res.node_out = handle_t'((cmd == OP_NEXT) ? lnk_next[h] : lnk_prev[h]);
			end
			OP_CLEAR: clear_list();
			OP_STATUS: begin
				if (live_total == 0)
					res.status = ST_EMPTY;
				else
					res.node_out = handle_t'(lnk_next[0]);
			end
			default: ;
		endcase
		// new node goes in front of pos, always in the next unused slot
		if (do_link) begin
			fresh                = slot_fill;
			pred                 = lnk_prev[pos];
			lnk_prev[fresh]      = pred;
			lnk_next[fresh]      = pos;
			val_mem[fresh]       = v;
			alive[fresh]         = 1'b1;
			lnk_next[pred]       = fresh;
			lnk_prev[pos]        = fresh;
			slot_fill++;
			live_total++;
			live_list[live_n]    = fresh;
			live_slot[fresh]     = live_n;
			live_n++;
			res.node_out         = handle_t'(fresh);
		end
		// unlink and report the successor; the slot is not reused
		if (do_unlink) begin
			pred                 = lnk_prev[target];
			succ                 = lnk_next[target];
			lnk_next[pred]       = succ;
			lnk_prev[succ]       = pred;
			alive[target]        = 1'b0;
			live_total--;
			idx                  = live_slot[target];
			live_list[idx]       = live_list[live_n-1];
			live_slot[live_list[idx]] = idx;
			live_n--;
			res.node_out         = handle_t'(succ);
		end
		res.count = handle_t'(live_total);
		return res;
	endfunction

	// weighted command choice
	function automatic op_t pick_op(bit growing);
		int r;
		int w;
		r = $urandom_range(0, 99);
		for (int k = 0; k < MIX_LEN; k++) begin
			w = growing ? MIX_GROW[k] : MIX_NORMAL[k];
			if (r < w)
				return (k == MIX_LEN - 1) ?
					op_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)) : op_t'(k);
			r -= w;
		end
		return OP_STATUS;
	endfunction

	// mostly live handles, some sentinel, erased and out-of-range ones
	function automatic handle_t pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70 && live_n > 0)
			return handle_t'(live_list[$urandom_range(0, live_n - 1)]);
		if (r < 78)
			return '0;
		if (r < 90)
			return handle_t'($urandom_range(0, slot_fill - 1));
		return handle_t'($urandom_range(0, POOL_NODES - 1));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// issue one transaction, with an optional idle burst in front
	task automatic drive_command(op_t c, handle_t h, value_t v, bit typed,
		list_result_t want, int idle_pct);
		list_result_t res;
		int           gap;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		op    <= c;
		node  <= h;
		value <= v;
		do @(posedge clk); while (busy);
		res = apply_command(c, h, v);
		awaited_results.insert(awaited_results.size(), typed ? want : res);
	endtask

	task automatic random_command(bit growing, int idle_pct);
		drive_command(pick_op(growing), pick_handle(), value_t'($urandom), 1'b0, '0, idle_pct);
	endtask

	// result checking and watchdog
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0)
					report_mismatch("result with no command pending", '0, '0);
				else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (node_out !== want.node_out)
						report_mismatch("node_out", node_out, want.node_out);
					if (value_out !== want.value_out)
						report_mismatch("value_out", value_out, want.value_out);
					if (count !== want.count)
						report_mismatch("count", count, want.count);
				end
			end
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL indexed_doubly_linked_list_unit");
				$finish;
			end
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// stimulus
	initial begin : stimulus
		int idle_pct;
		start        = 1'b0;
		op           = OP_STATUS;
		node         = '0;
		value        = '0;
		arst_n       = 1'b0;
		mismatches   = 0;
		stall_cycles = 0;
		clear_list();

		// directed table: typed expectations for the obvious rows
		dir_rows[0]  = '{OP_STATUS, 10'd0, 32'd0, 1'b1, '{ST_EMPTY, 10'd0, 32'd0, 10'd0}};
		dir_rows[1]  = '{OP_GET, 10'd0, 32'd0, 1'b1, '{ST_OK, 10'd0, 32'd0, 10'd0}};
		dir_rows[2]  = '{OP_POP_FRONT, 10'd0, 32'd0, 1'b1, '{ST_EMPTY, 10'd0, 32'd0, 10'd0}};
		dir_rows[3]  = '{OP_POP_BACK, 10'd0, 32'd0, 1'b1, '{ST_EMPTY, 10'd0, 32'd0, 10'd0}};
		dir_rows[4]  = '{OP_ERASE, 10'd0, 32'd0, 1'b1, '{ST_BAD, 10'd0, 32'd0, 10'd0}};
		dir_rows[5]  = '{OP_NEXT, 10'd5, 32'd0, 1'b1, '{ST_BAD, 10'd0, 32'd0, 10'd0}};
		dir_rows[6]  = '{OP_GET, 10'd1023, 32'd0, 1'b1, '{ST_BAD, 10'd0, 32'd0, 10'd0}};
		dir_rows[7]  = '{OP_INS_BEFORE, 10'd1, 32'd7, 1'b1, '{ST_BAD, 10'd0, 32'd0, 10'd0}};
		dir_rows[8]  = '{OP_NEXT, 10'd0, 32'd0, 1'b1, '{ST_OK, 10'd0, 32'd0, 10'd0}};
		dir_rows[9]  = '{OP_PREV, 10'd0, 32'd0, 1'b1, '{ST_OK, 10'd0, 32'd0, 10'd0}};
		dir_rows[10] = '{OP_PUSH_BACK, 10'd0, 32'hFFFF_FFFF, 1'b1,
			'{ST_OK, 10'd1, 32'd0, 10'd1}};
		dir_rows[11] = '{OP_PUSH_FRONT, 10'd0, 32'd0, 1'b1, '{ST_OK, 10'd2, 32'd0, 10'd2}};
		dir_rows[12] = '{OP_INS_AFTER, 10'd1, 32'hA5A5_A5A5, 1'b0, '0};
		dir_rows[13] = '{OP_INS_BEFORE, 10'd2, 32'h5A5A_5A5A, 1'b0, '0};
		dir_rows[14] = '{OP_GET, 10'd1, 32'd0, 1'b1, '{ST_OK, 10'd0, 32'hFFFF_FFFF, 10'd4}};
		dir_rows[15] = '{OP_NEXT, 10'd1, 32'd0, 1'b0, '0};
		dir_rows[16] = '{OP_PREV, 10'd2, 32'd0, 1'b0, '0};
		dir_rows[17] = '{OP_STATUS, 10'd0, 32'd0, 1'b0, '0};
		dir_rows[18] = '{OP_ERASE, 10'd1, 32'd0, 1'b0, '0};
		dir_rows[19] = '{OP_GET, 10'd1, 32'd0, 1'b1, '{ST_BAD, 10'd0, 32'hFFFF_FFFF, 10'd3}};
		dir_rows[20] = '{OP_ERASE, 10'd1, 32'd0, 1'b1, '{ST_BAD, 10'd0, 32'd0, 10'd3}};
		dir_rows[21] = '{OP_POP_FRONT, 10'd0, 32'd0, 1'b0, '0};
		dir_rows[22] = '{OP_POP_BACK, 10'd0, 32'd0, 1'b0, '0};
		dir_rows[23] = '{OP_UNUSED_LO, 10'd3, 32'h1234_5678, 1'b0, '0};
		dir_rows[24] = '{OP_UNUSED_HI, 10'd1023, 32'hFFFF_FFFF, 1'b0, '0};
		dir_rows[25] = '{OP_CLEAR, 10'd0, 32'd0, 1'b1, '{ST_OK, 10'd0, 32'd0, 10'd0}};
		dir_rows[26] = '{OP_GET, 10'd2, 32'd0, 1'b1, '{ST_BAD, 10'd0, 32'd0, 10'd0}};

		// reset
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			drive_command(dir_rows[i].cmd, dir_rows[i].h, dir_rows[i].v,
				dir_rows[i].typed, dir_rows[i].want, 20);

		// mixed traffic on short lists, occasional clears
		idle_pct = 0;
		for (int i = 0; i < 300; i++) begin
			if (i % 40 == 0)
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			random_command(1'b0, idle_pct);
		end

		// grow from empty until the pool is used up, then keep hitting it
		drive_command(OP_CLEAR, '0, '0, 1'b0, '0, 0);
		for (int i = 0; slot_fill < POOL_NODES; i++) begin
			if (i % 40 == 0)
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			random_command(1'b1, idle_pct);
		end
		for (int i = 0; i < 60; i++)
			random_command(1'b1, 15);

		// back to back, no idling
		drive_command(OP_CLEAR, '0, '0, 1'b0, '0, 0);
		for (int i = 0; i < 150; i++)
			random_command(1'b0, 0);

		@(negedge clk);
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS indexed_doubly_linked_list_unit");
		else
			$display("FAIL indexed_doubly_linked_list_unit");
		$finish;
	end

endmodule
